@@ rtl/assert_macros.svh @@
// Assertion macros for the door lock controller, included by door_lock_controller.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define DLC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check on every clock edge, reset included.
`define DLC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ rtl/dlc_pkg.sv @@
// Types and constants of the door lock controller.
`timescale 1ns / 1ps

package dlc_pkg;

    localparam int TIME_W    = 24;
    localparam int ELAPSED_W = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_WELCOME_TIME   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_LOCK_TIME = 2'd1;

    typedef enum logic [1:0] {
        CMD_LOCK   = 2'd0,
        CMD_UNLOCK = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_RESET  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_LOCKED   = 2'd0,
        ST_UNLOCKED = 2'd1,
        ST_WELCOME  = 2'd2
    } lock_state_t;

    typedef struct packed {
        lock_state_t         lock_state;
        logic                welcome_running;
        logic [TIME_W-1:0]   welcome_left;
        logic                autolock_running;
        logic [TIME_W-1:0]   autolock_left;
    } ctrl_state_t;

    typedef struct packed {
        lock_state_t door_state;
        logic        lock_lamp_on;
        logic        drl_lamp_on;
        logic        beep_lock;
        logic        beep_unlock;
        logic        lock_denied;
    } result_t;

endpackage

@@ rtl/dlc_step.sv @@
// Next-state and result logic for one lock controller command.
`timescale 1ns / 1ps

module dlc_step import dlc_pkg::*; (
    input  ctrl_state_t          cur,
    input  cmd_t                 command,
    input  logic                 door_ajar,
    input  logic [ELAPSED_W-1:0] elapsed_ms,
    input  logic [TIME_W-1:0]    welcome_time_ms,
    input  logic [TIME_W-1:0]    auto_lock_time_ms,
    output ctrl_state_t          nxt,
    output result_t              res
);

    logic [TIME_W-1:0] dt;
    logic              welcome_hit;
    logic              autolock_hit;
    logic              beep_lock;
    logic              beep_unlock;
    logic              refused;

    assign dt = {{(TIME_W-ELAPSED_W){1'b0}}, elapsed_ms};

    always_comb begin
        nxt          = cur;
        beep_lock    = 1'b0;
        beep_unlock  = 1'b0;
        refused      = 1'b0;
        welcome_hit  = cur.welcome_running && (dt >= cur.welcome_left);
        autolock_hit = 1'b0;
        case (command)
            CMD_LOCK: begin
                if (cur.lock_state == ST_UNLOCKED || cur.lock_state == ST_WELCOME) begin
                    if (door_ajar) begin
                        refused = 1'b1;
                    end else begin
                        nxt.lock_state       = ST_LOCKED;
                        nxt.welcome_running  = 1'b0;
                        nxt.welcome_left     = '0;
                        nxt.autolock_running = 1'b0;
                        nxt.autolock_left    = '0;
                        beep_lock            = 1'b1;
                    end
                end
            end
            CMD_UNLOCK: begin
                if (cur.lock_state == ST_LOCKED) begin
                    nxt.lock_state       = ST_WELCOME;
                    nxt.welcome_running  = 1'b1;
                    nxt.welcome_left     = welcome_time_ms;
                    nxt.autolock_running = 1'b0;
                    nxt.autolock_left    = '0;
                    beep_unlock          = 1'b1;
                end
            end
            CMD_TICK: begin
                // Welcome countdown first; its expiry arms the auto-lock countdown.
                if (welcome_hit) begin
                    nxt.welcome_running = 1'b0;
                    nxt.welcome_left    = '0;
                    if (cur.lock_state == ST_WELCOME) begin
                        nxt.lock_state = ST_UNLOCKED;
                    end
                    nxt.autolock_running = 1'b1;
                    nxt.autolock_left    = auto_lock_time_ms;
                end else if (cur.welcome_running) begin
                    nxt.welcome_left = cur.welcome_left - dt;
                end
                // Same elapsed time applies to the (possibly fresh) auto-lock countdown.
                autolock_hit = nxt.autolock_running && (dt >= nxt.autolock_left);
                if (autolock_hit) begin
                    if (nxt.lock_state == ST_UNLOCKED && !door_ajar) begin
                        nxt.lock_state       = ST_LOCKED;
                        nxt.autolock_running = 1'b0;
                        nxt.autolock_left    = '0;
                        beep_lock            = 1'b1;
                    end else begin
                        nxt.autolock_running = 1'b1;
                        nxt.autolock_left    = auto_lock_time_ms;
                    end
                end else if (nxt.autolock_running) begin
                    nxt.autolock_left = nxt.autolock_left - dt;
                end
            end
            default: begin
                nxt.lock_state       = ST_LOCKED;
                nxt.welcome_running  = 1'b0;
                nxt.welcome_left     = '0;
                nxt.autolock_running = 1'b0;
                nxt.autolock_left    = '0;
            end
        endcase
    end

    assign res.door_state   = nxt.lock_state;
    assign res.lock_lamp_on = (nxt.lock_state == ST_LOCKED);
    assign res.drl_lamp_on  = (nxt.lock_state == ST_WELCOME);
    assign res.beep_lock    = beep_lock;
    assign res.beep_unlock  = beep_unlock;
    assign res.lock_denied  = refused;

endmodule

@@ rtl/door_lock_controller.sv @@
// Door lock controller top level: input register, state, result register, config.
// Each item is held in the input register, then in the result register, before it shows on the m_ side.
// Throughput: 1 item per cycle unless m_ready stalls; the state update is one compare/subtract pass per timer.
// A new transfer is taken while a finished result still waits for m_ready.
// Reset (aresetn, synchronous, active low): locked, timers stopped, time registers 0.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module door_lock_controller import dlc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [TIME_W-1:0]    cfg_wdata,
    // command channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_command,
    input  logic                 s_door_ajar,
    input  logic [ELAPSED_W-1:0] s_elapsed_ms,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_door_state,
    output logic                 m_lock_lamp_on,
    output logic                 m_drl_lamp_on,
    output logic                 m_beep_lock,
    output logic                 m_beep_unlock,
    output logic                 m_lock_denied
);

    // Configuration registers.
    logic [TIME_W-1:0]    welcome_time_reg;
    logic [TIME_W-1:0]    auto_lock_time_reg;

    // Input register stage.
    logic                 in_valid_reg;
    cmd_t                 command_reg;
    logic                 door_ajar_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;

    // Controller state and its next value.
    ctrl_state_t          state_reg;
    ctrl_state_t          state_next;

    // Result register stage.
    logic                 out_valid_reg;
    result_t              result_reg;
    result_t              result_next;

    logic                 advance;

    // Assertion helpers.
    logic                 welcome_timer_ok;
    logic                 autolock_timer_ok;
    logic                 refused_shown;
    logic                 refused_clean;
    logic                 stages_empty;

    // The item in the input register moves on whenever the result slot is free
    // or is being emptied in this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Write the time registers; drop writes to unknown indexes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            welcome_time_reg   <= '0;
            auto_lock_time_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_WELCOME_TIME:   welcome_time_reg   <= cfg_wdata;
                REG_AUTO_LOCK_TIME: auto_lock_time_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Capture the command on an input transfer; hold it until it advances.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            command_reg   <= cmd_t'(s_command);
            door_ajar_reg <= s_door_ajar;
            elapsed_reg   <= s_elapsed_ms;
        end
    end

    dlc_step u_step (
        .cur               (state_reg),
        .command           (command_reg),
        .door_ajar         (door_ajar_reg),
        .elapsed_ms        (elapsed_reg),
        .welcome_time_ms   (welcome_time_reg),
        .auto_lock_time_ms (auto_lock_time_reg),
        .nxt               (state_next),
        .res               (result_next)
    );

    // Commit the new state together with the result, so the next command
    // sees the state left by this one.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Pulses live only in the result of their own item.
    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_door_state   = result_reg.door_state;
    assign m_lock_lamp_on = result_reg.lock_lamp_on;
    assign m_drl_lamp_on  = result_reg.drl_lamp_on;
    assign m_beep_lock    = result_reg.beep_lock;
    assign m_beep_unlock  = result_reg.beep_unlock;
    assign m_lock_denied  = result_reg.lock_denied;

    assign welcome_timer_ok  = (state_reg.lock_state == ST_WELCOME) ==
                               state_reg.welcome_running;
    assign autolock_timer_ok = (state_reg.lock_state == ST_UNLOCKED) ==
                               state_reg.autolock_running;
    assign refused_shown     = out_valid_reg && result_reg.lock_denied;
    assign refused_clean     = !result_reg.beep_lock && !result_reg.beep_unlock &&
                               !result_reg.lock_lamp_on;
    assign stages_empty      = !out_valid_reg && !in_valid_reg;

    // The welcome countdown runs exactly while in welcome.
    `DLC_ASSERT(a_welcome_timer, welcome_timer_ok, "welcome timer out of step with state")
    // The auto-lock countdown runs exactly while unlocked.
    `DLC_ASSERT(a_autolock_timer, autolock_timer_ok, "auto-lock timer out of step with state")
    // A refused lock leaves the door unlocked and fires no chirp.
    `DLC_ASSERT(a_refused_excl, refused_shown |-> refused_clean, "refused lock with chirp or lamp")
    // Reset empties both stages.
    `DLC_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> stages_empty, "pipeline not empty after reset")

endmodule
